// ===== sv/spg_pkg.sv =====
// Shared types and constants of the servo pulse generator.
package spg_pkg;

    localparam int unsigned CAL_ENTRY_W = 12;
    localparam int unsigned CAL_ENTRIES = 5;
    localparam int unsigned CAL_W       = CAL_ENTRY_W * CAL_ENTRIES;
    localparam int unsigned PULSE_W     = 12;
    localparam int unsigned ANGLE_W     = 13;
    localparam int unsigned CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_CAL_A = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAL_B = 1'b1;

    localparam logic [CAL_W-1:0] CAL_A_RESET = 60'h8986A45143841F4;
    localparam logic [CAL_W-1:0] CAL_B_RESET = 60'h9C486564041B1F4;

    // per-channel control for one item leaving the pulse pipeline
    typedef struct packed {
        logic en;
        logic set;
        logic tick;
    } t_chan_ctl;

endpackage

// ===== sv/spg_interp.sv =====
// Two-stage piecewise linear map from angle to pulse width.
module spg_interp (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [spg_pkg::ANGLE_W-1:0]    i_angle,
    input  logic        [spg_pkg::CAL_W-1:0]      i_cal,
    output logic        [spg_pkg::PULSE_W-1:0]    o_pulse_width
);
    import spg_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ANG_LIM = 13'sd1440;
    localparam logic [11:0] SEG1 = 12'd720;
    localparam logic [11:0] SEG2 = 12'd1440;
    localparam logic [11:0] SEG3 = 12'd2160;
    // bias that makes the product non-negative: 720 * 4096
    localparam logic signed [23:0] NUM_BIAS = 24'sd2949120;
    // ceil(2^24 / 45), exact for dividends up to 381300
    localparam logic [18:0] RECIP_45 = 19'd372828;

    logic signed [ANGLE_W-1:0] ang_c;
    logic signed [ANGLE_W-1:0] s_full;
    logic [11:0]               s;
    logic [1:0]                seg;
    logic [11:0]               base;
    logic [9:0]                off;
    logic [CAL_ENTRY_W-1:0]    lo;
    logic [CAL_ENTRY_W-1:0]    hi;
    logic signed [12:0]        diff;
    logic signed [23:0]        n_num;

    logic signed [23:0]        r_num;
    logic [CAL_ENTRY_W-1:0]    r_lo;

    logic signed [23:0]        biased;
    logic [18:0]               y16;
    logic [37:0]               prod;

    always_comb begin
        priority if (i_angle < -ANG_LIM) begin
            ang_c = -ANG_LIM;
        end else if (i_angle > ANG_LIM) begin
            ang_c = ANG_LIM;
        end else begin
            ang_c = i_angle;
        end
        s_full = ang_c + ANG_LIM;
        s      = s_full[11:0];

        priority if (s >= SEG3) begin
            seg = 2'd3;
        end else if (s >= SEG2) begin
            seg = 2'd2;
        end else if (s >= SEG1) begin
            seg = 2'd1;
        end else begin
            seg = 2'd0;
        end

        unique case (seg)
            2'd0: begin
                base = 12'd0;
                lo   = i_cal[11:0];
                hi   = i_cal[23:12];
            end
            2'd1: begin
                base = SEG1;
                lo   = i_cal[23:12];
                hi   = i_cal[35:24];
            end
            2'd2: begin
                base = SEG2;
                lo   = i_cal[35:24];
                hi   = i_cal[47:36];
            end
            default: begin
                base = SEG3;
                lo   = i_cal[47:36];
                hi   = i_cal[59:48];
            end
        endcase

        off   = 10'(s - base);
        diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
        n_num = 24'($signed({1'b0, off})) * 24'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_lo  <= lo;
        end
    end

    // floor(num / 720) = floor(floor(num / 16) / 45), biased to stay unsigned;
    // the bias adds 4096 to the quotient, which vanishes modulo 2^12
    always_comb begin
        biased        = r_num + NUM_BIAS;
        y16           = biased[22:4];
        prod          = 38'(y16) * 38'(RECIP_45);
        o_pulse_width = r_lo + prod[35:24];
    end

endmodule

// ===== sv/spg_channel.sv =====
// Burst frame counter and line level of one servo channel.
module spg_channel #(
    parameter int unsigned FRAME_TICKS  = 20000,
    parameter int unsigned BURST_FRAMES = 50
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spg_pkg::t_chan_ctl              i_ctl,
    input  logic [spg_pkg::PULSE_W-1:0]     i_pulse_width,
    output logic                            o_level,
    output logic                            o_busy_next
);
    import spg_pkg::*;

    localparam int unsigned FT_W = $clog2(FRAME_TICKS);
    localparam int unsigned FR_W = $clog2(BURST_FRAMES + 1);

    logic [PULSE_W-1:0] r_pulse;
    logic [FT_W-1:0]    r_count;
    logic [FR_W-1:0]    r_frames;
    logic [FT_W-1:0]    n_count;
    logic [FR_W-1:0]    n_frames;
    logic               active;

    assign active  = (r_frames != '0);
    assign o_level = i_ctl.tick && active && (r_count < FT_W'(r_pulse));

    always_comb begin
        n_count  = r_count;
        n_frames = r_frames;
        if (i_ctl.set) begin
            n_count  = '0;
            n_frames = FR_W'(BURST_FRAMES);
        end else if (i_ctl.tick && active) begin
            if (r_count == FT_W'(FRAME_TICKS - 1)) begin
                n_count  = '0;
                n_frames = r_frames - 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign o_busy_next = (n_frames != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_frames <= '0;
        end else if (i_ctl.en) begin
            r_count  <= n_count;
            r_frames <= n_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.set) begin
            r_pulse <= i_pulse_width;
        end
    end

endmodule

// ===== sv/servo_pulse_generator_core.sv =====
// Two-channel servo pulse generator with calibrated angle-to-pulse mapping.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | i_valid / o_stall          | i_func, i_servo_select, i_angle
//  out     | o_valid / i_stall          | o_line_level_a/b, o_pulse_width, o_busy_a/b
//  cfg     | i_cfg_we                   | i_cfg_addr, i_cfg_data
//
// One item per cycle while the output is not stalled; an accepted item passes the
// input register, the product register and the result register before o_valid rises.
// The multiply-by-reciprocal division by 720 in the second stage sets the cycle time.
// Synchronous active-low reset clears pipeline valids and the burst counters;
// calibration registers return to their default tables.
// A stall on the output freezes the whole pipeline; a one-item skid register at the
// input absorbs the item in flight, and o_stall is that register's valid flag.
module servo_pulse_generator_core #(
    parameter int unsigned FRAME_TICKS  = 20000,
    parameter int unsigned BURST_FRAMES = 50
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input items
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_func,
    input  logic                                   i_servo_select,
    input  logic signed [spg_pkg::ANGLE_W-1:0]     i_angle,
    // result items
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_line_level_a,
    output logic                                   o_line_level_b,
    output logic        [spg_pkg::PULSE_W-1:0]     o_pulse_width,
    output logic                                   o_busy_a,
    output logic                                   o_busy_b,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic        [spg_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic        [spg_pkg::CAL_W-1:0]       i_cfg_data
);
    import spg_pkg::*;

    // calibration tables
    logic [CAL_W-1:0] r_cal_a;
    logic [CAL_W-1:0] r_cal_b;

    // input skid register
    logic                      r_skid_valid;
    logic                      r_skid_func;
    logic                      r_skid_sel;
    logic signed [ANGLE_W-1:0] r_skid_angle;

    // stage A: accepted item
    logic                      r_a_valid;
    logic                      r_a_func;
    logic                      r_a_sel;
    logic signed [ANGLE_W-1:0] r_a_angle;

    // stage B: product registered inside the interpolator
    logic                      r_b_valid;
    logic                      r_b_func;
    logic                      r_b_sel;

    logic                      advance;
    logic                      take;
    logic [PULSE_W-1:0]        pulse_b;
    t_chan_ctl                 ctl_a;
    t_chan_ctl                 ctl_b;
    logic                      level_a;
    logic                      level_b;
    logic                      busy_a_next;
    logic                      busy_b_next;

    // Move the pipeline whenever the result register is free or being emptied.
    assign advance = !o_valid || !i_stall;
    assign o_stall = r_skid_valid;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= CAL_A_RESET;
            r_cal_b <= CAL_B_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CAL_A: r_cal_a <= i_cfg_data;
                CFG_CAL_B: r_cal_b <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Valid flags of skid, stages and result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            o_valid      <= 1'b0;
        end else if (advance) begin
            r_skid_valid <= 1'b0;
            r_a_valid    <= r_skid_valid || take;
            r_b_valid    <= r_a_valid;
            o_valid      <= r_b_valid;
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (!advance && take) begin
            r_skid_func  <= i_func;
            r_skid_sel   <= i_servo_select;
            r_skid_angle <= i_angle;
        end
        if (advance) begin
            if (r_skid_valid) begin
                r_a_func  <= r_skid_func;
                r_a_sel   <= r_skid_sel;
                r_a_angle <= r_skid_angle;
            end else begin
                r_a_func  <= i_func;
                r_a_sel   <= i_servo_select;
                r_a_angle <= i_angle;
            end
            r_b_func <= r_a_func;
            r_b_sel  <= r_a_sel;
            if (r_b_valid) begin
                o_line_level_a <= level_a;
                o_line_level_b <= level_b;
                o_pulse_width  <= r_b_func ? pulse_b : '0;
                o_busy_a       <= busy_a_next;
                o_busy_b       <= busy_b_next;
            end
        end
    end

    spg_interp u_interp (
        .i_clk         (i_clk),
        .i_en          (advance),
        .i_angle       (r_a_angle),
        .i_cal         (r_a_sel ? r_cal_b : r_cal_a),
        .o_pulse_width (pulse_b)
    );

    // Channel state changes only as an item enters the result register.
    always_comb begin
        ctl_a.en   = advance && r_b_valid;
        ctl_a.set  = r_b_func && !r_b_sel;
        ctl_a.tick = !r_b_func;
        ctl_b.en   = advance && r_b_valid;
        ctl_b.set  = r_b_func && r_b_sel;
        ctl_b.tick = !r_b_func;
    end

    spg_channel #(
        .FRAME_TICKS  (FRAME_TICKS),
        .BURST_FRAMES (BURST_FRAMES)
    ) u_chan_a (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl_a),
        .i_pulse_width (pulse_b),
        .o_level       (level_a),
        .o_busy_next   (busy_a_next)
    );

    spg_channel #(
        .FRAME_TICKS  (FRAME_TICKS),
        .BURST_FRAMES (BURST_FRAMES)
    ) u_chan_b (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl_b),
        .i_pulse_width (pulse_b),
        .o_level       (level_b),
        .o_busy_next   (busy_b_next)
    );

`ifndef SYNTHESIS
    // A high line in a tick can never be the last tick of a burst.
    a_level_a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_level_a |-> o_busy_a)
        else $error("channel a high while burst ended");

    a_level_b_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_level_b |-> o_busy_b)
        else $error("channel b high while burst ended");

    // A nonzero pulse only comes from a set item, which starts a burst and drives no line.
    a_set_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pulse_width != '0) |->
            !o_line_level_a && !o_line_level_b && (o_busy_a || o_busy_b))
        else $error("set result inconsistent");

    // The skid entry is held until the pipeline moves.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !advance |=> r_skid_valid)
        else $error("skid item lost");
`endif

endmodule
